// ===== rtl/afsp_pkg.sv =====
// ----------------------------------------------------------------------------
// afsp_pkg
// Shared types, character codes and frame constants for the ASCII frame
// sample parser.
// ----------------------------------------------------------------------------
package afsp_pkg;

	localparam int REAL_SAMPLES  = 1015;
	localparam int FRAME_SAMPLES = 1024;
	localparam int FIELD_DIGITS  = 6;
	localparam int HEX_DIGITS    = 3;

	localparam int NUM_FIELDS = 4;
	localparam int IDX_W      = 10;
	localparam int VAL_W      = 20;
	localparam int SMP_W      = 12;
	localparam int FCNT_W     = 3;
	localparam int HCNT_W     = 2;

	// padded copies exist only when the frame is longer than the real data
	localparam bit PAD_ROOM = (FRAME_SAMPLES > REAL_SAMPLES);

	localparam logic [7:0] CH_S     = 8'h53;
	localparam logic [7:0] CH_P     = 8'h70;
	localparam logic [7:0] CH_N     = 8'h6e;
	localparam logic [7:0] CH_D     = 8'h64;
	localparam logic [7:0] CH_C     = 8'h63;
	localparam logic [7:0] CH_COMMA = 8'h2c;
	localparam logic [7:0] CH_DOT   = 8'h2e;
	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_9     = 8'h39;
	localparam logic [7:0] CH_LA    = 8'h61;
	localparam logic [7:0] CH_LF    = 8'h66;
	localparam logic [7:0] CH_UA    = 8'h41;
	localparam logic [7:0] CH_UF    = 8'h46;

	// field order p, n, d, c; entry 0 in the low byte
	localparam logic [NUM_FIELDS-1:0][7:0] FIELD_LETTER = {CH_C, CH_D, CH_N, CH_P};

	typedef enum logic [2:0] {
		KIND_SAMPLE   = 3'd0,
		KIND_PREAMBLE = 3'd1,
		KIND_COUNT    = 3'd2,
		KIND_CLKDIV   = 3'd3,
		KIND_CPUKHZ   = 3'd4
	} kind_t;

	// results still owed for one accepted item
	typedef struct packed {
		logic [NUM_FIELDS-1:0]            meta_mask;
		logic [NUM_FIELDS-1:0][VAL_W-1:0] meta_val;
		logic                             smp_pend;
		logic                             smp_done;
		logic [IDX_W-1:0]                 smp_idx;
		logic [SMP_W-1:0]                 smp_val;
		logic                             pad_pend;
		logic [IDX_W-1:0]                 pad_idx;
	} job_t;

	// {valid, nibble}
	function automatic logic [4:0] hex_decode(input logic [7:0] b);
		logic [4:0] r;
		r = '0;
		if (b inside {[CH_0:CH_9]}) begin
			r = {1'b1, 4'(b - CH_0)};
		end else if (b inside {[CH_LA:CH_LF]}) begin
			r = {1'b1, 4'(b - CH_LA + 8'd10)};
		end else if (b inside {[CH_UA:CH_UF]}) begin
			r = {1'b1, 4'(b - CH_UA + 8'd10)};
		end
		return r;
	endfunction

endpackage

// ===== rtl/ascii_frame_sample_parser.sv =====
// ----------------------------------------------------------------------------
// ascii_frame_sample_parser
// Parses a byte stream of metadata fields and comma separated hex samples
// into typed result items, with padding at the end of a frame.
// ----------------------------------------------------------------------------
// The first result of an item is held in the job register, then in the output register.
// Throughput: one item per cycle while each item causes at most one result and
// the output is not stalled; after an item with more results the next item waits
// for its last result to move out (set by the single result register, one result
// per unstalled cycle; the last sample and its padding give 1 + FRAME_SAMPLES - REAL_SAMPLES results).
// Reset: arst_n clears all parser state and drops every pending result.
module ascii_frame_sample_parser
	import afsp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] rx_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [9:0] sample_index, [29:10] result_value, [31:30] 0
	output logic [3:0]  m_tuser,   // [2:0] result_kind, [3] frame_done
	output logic        m_tlast    // run_last
);

	// parser state
	logic                                  meta_q, meta_d;
	logic [NUM_FIELDS-1:0]                 fld_act_q, fld_act_d;
	logic [NUM_FIELDS-1:0][FCNT_W-1:0]     fld_cnt_q, fld_cnt_d;
	logic [NUM_FIELDS-1:0][VAL_W-1:0]      fld_acc_q, fld_acc_d;
	logic [NUM_FIELDS-1:0]                 fld_stop_q, fld_stop_d;
	logic                                  data_q, data_d;
	logic [HCNT_W-1:0]                     hcnt_q, hcnt_d;
	logic [SMP_W-1:0]                      hacc_q, hacc_d;
	logic                                  hstop_q, hstop_d;
	logic [IDX_W-1:0]                      scnt_q, scnt_d;

	job_t       job_q, job_new, job_next;
	logic       job_busy, next_busy, out_free, move, accept;
	logic [4:0] hex_r;
	logic       dig_ok;
	logic [3:0] dig;

	// head-of-job result
	kind_t             h_kind;
	logic [IDX_W-1:0]  h_idx;
	logic [VAL_W-1:0]  h_val;
	logic              h_done;

	logic              out_v_q;
	kind_t             out_kind_q;
	logic [IDX_W-1:0]  out_idx_q;
	logic [VAL_W-1:0]  out_val_q;
	logic              out_done_q;
	logic              out_last_q;

	assign hex_r  = hex_decode(s_tdata);
	assign dig_ok = (s_tdata >= CH_0) && (s_tdata <= CH_9);
	assign dig    = 4'(s_tdata - CH_0);

	// next state and new job from the incoming item
	always_comb begin
		meta_d     = meta_q;
		fld_act_d  = fld_act_q;
		fld_cnt_d  = fld_cnt_q;
		fld_acc_d  = fld_acc_q;
		fld_stop_d = fld_stop_q;
		data_d     = data_q;
		hcnt_d     = hcnt_q;
		hacc_d     = hacc_q;
		hstop_d    = hstop_q;
		scnt_d     = scnt_q;
		job_new         = '0;
		job_new.pad_idx = IDX_W'(REAL_SAMPLES);

		if (s_tdata == CH_DOT) begin
			data_d = 1'b0;
			scnt_d = '0;
		end else begin
			if (s_tdata == CH_S || meta_q) begin
				meta_d = 1'b1;
				for (int f = 0; f < NUM_FIELDS; f++) begin
					if (s_tdata == FIELD_LETTER[f]) begin
						fld_act_d[f]  = 1'b1;
						fld_cnt_d[f]  = '0;
						fld_acc_d[f]  = '0;
						fld_stop_d[f] = 1'b0;
					end else if (fld_act_q[f]) begin
						if (!fld_stop_q[f] && dig_ok) begin
							fld_acc_d[f] = VAL_W'(fld_acc_q[f] * VAL_W'(10) + VAL_W'(dig));
						end else begin
							fld_stop_d[f] = 1'b1;
						end
						if (fld_cnt_q[f] == FCNT_W'(FIELD_DIGITS - 1)) begin
							fld_act_d[f]         = 1'b0;
							fld_cnt_d[f]         = '0;
							job_new.meta_mask[f] = 1'b1;
							job_new.meta_val[f]  = fld_acc_d[f];
							// closing the last field switches to sample data
							if (f == NUM_FIELDS - 1) begin
								meta_d  = 1'b0;
								data_d  = 1'b1;
								scnt_d  = '0;
								hcnt_d  = '0;
								hacc_d  = '0;
								hstop_d = 1'b0;
							end
						end else begin
							fld_cnt_d[f] = fld_cnt_q[f] + FCNT_W'(1);
						end
					end
				end
			end

			if (data_d) begin
				if (s_tdata == CH_COMMA) begin
					hcnt_d  = '0;
					hacc_d  = '0;
					hstop_d = 1'b0;
				end else if (hcnt_d < HCNT_W'(HEX_DIGITS)) begin
					if (!hstop_d && hex_r[4]) begin
						hacc_d = SMP_W'({hacc_d, hex_r[3:0]});
					end else begin
						hstop_d = 1'b1;
					end
					if (hcnt_d == HCNT_W'(HEX_DIGITS - 1)) begin
						job_new.smp_pend = 1'b1;
						job_new.smp_idx  = scnt_d;
						job_new.smp_val  = hacc_d;
						if ({1'b0, scnt_d} + (IDX_W+1)'(1) >= (IDX_W+1)'(REAL_SAMPLES)) begin
							data_d           = 1'b0;
							job_new.smp_done = !PAD_ROOM;
							job_new.pad_pend = PAD_ROOM;
						end
						scnt_d = scnt_d + IDX_W'(1);
					end
					hcnt_d = hcnt_d + HCNT_W'(1);
				end
			end
		end
	end

	// pick the head result and the job that remains after it
	always_comb begin
		job_next = job_q;
		h_kind   = KIND_SAMPLE;
		h_idx    = '0;
		h_val    = '0;
		h_done   = 1'b0;
		if (job_q.meta_mask[0]) begin
			h_kind = KIND_PREAMBLE;
			h_val  = job_q.meta_val[0];
			job_next.meta_mask[0] = 1'b0;
		end else if (job_q.meta_mask[1]) begin
			h_kind = KIND_COUNT;
			h_val  = job_q.meta_val[1];
			job_next.meta_mask[1] = 1'b0;
		end else if (job_q.meta_mask[2]) begin
			h_kind = KIND_CLKDIV;
			h_val  = job_q.meta_val[2];
			job_next.meta_mask[2] = 1'b0;
		end else if (job_q.meta_mask[3]) begin
			h_kind = KIND_CPUKHZ;
			h_val  = job_q.meta_val[3];
			job_next.meta_mask[3] = 1'b0;
		end else if (job_q.smp_pend) begin
			h_idx  = job_q.smp_idx;
			h_val  = VAL_W'(job_q.smp_val);
			h_done = job_q.smp_done;
			job_next.smp_pend = 1'b0;
		end else begin
			h_idx  = job_q.pad_idx;
			h_val  = VAL_W'(job_q.smp_val);
			h_done = (job_q.pad_idx == IDX_W'(FRAME_SAMPLES - 1));
			job_next.pad_idx = job_q.pad_idx + IDX_W'(1);
			if (h_done) begin
				job_next.pad_pend = 1'b0;
			end
		end
	end

	assign job_busy  = (|job_q.meta_mask) || job_q.smp_pend || job_q.pad_pend;
	assign next_busy = (|job_next.meta_mask) || job_next.smp_pend || job_next.pad_pend;
	assign out_free  = !out_v_q || m_tready;
	assign move      = out_free && job_busy;
	assign s_tready  = !job_busy || (move && !next_busy);
	assign accept    = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			meta_q     <= 1'b0;
			fld_act_q  <= '0;
			fld_cnt_q  <= '0;
			fld_acc_q  <= '0;
			fld_stop_q <= '0;
			data_q     <= 1'b0;
			hcnt_q     <= '0;
			hacc_q     <= '0;
			hstop_q    <= 1'b0;
			scnt_q     <= '0;
		end else if (accept) begin
			meta_q     <= meta_d;
			fld_act_q  <= fld_act_d;
			fld_cnt_q  <= fld_cnt_d;
			fld_acc_q  <= fld_acc_d;
			fld_stop_q <= fld_stop_d;
			data_q     <= data_d;
			hcnt_q     <= hcnt_d;
			hacc_q     <= hacc_d;
			hstop_q    <= hstop_d;
			scnt_q     <= scnt_d;
		end
	end

	// results still owed by the last accepted item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			job_q <= '0;
		end else if (accept) begin
			job_q <= job_new;
		end else if (move) begin
			job_q <= job_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (move) begin
			out_v_q <= 1'b1;
		end else if (m_tready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (move) begin
			out_kind_q <= h_kind;
			out_idx_q  <= h_idx;
			out_val_q  <= h_val;
			out_done_q <= h_done;
			out_last_q <= !next_busy;
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = {2'b00, out_val_q, out_idx_q};
	assign m_tuser  = {out_done_q, out_kind_q};
	assign m_tlast  = out_last_q;

	// frame end always closes the results of its item
	a_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_v_q && out_done_q |-> out_last_q)
		else $error("frame_done without run_last");

	// metadata results carry index zero
	a_meta_idx: assert property (@(posedge clk) disable iff (!arst_n)
		out_v_q && (out_kind_q != KIND_SAMPLE) |-> (out_idx_q == '0))
		else $error("metadata result with nonzero index");

	// padding index stays inside the padded range
	a_pad_range: assert property (@(posedge clk) disable iff (!arst_n)
		job_q.pad_pend |-> (job_q.pad_idx >= IDX_W'(REAL_SAMPLES)))
		else $error("padding index below real sample range");

	// abort byte leaves data mode off with the index cleared
	a_abort: assert property (@(posedge clk) disable iff (!arst_n)
		accept && (s_tdata == CH_DOT) |=> !data_q && (scnt_q == '0))
		else $error("abort did not clear data mode");

	// a new item is taken only when no results of the previous one remain
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> !job_busy || (move && !next_busy))
		else $error("item accepted over pending results");

endmodule

// ===== bench/afsp_result_checker.sv =====
// ----------------------------------------------------------------------------
// afsp_result_checker
// Watches both streams of the ASCII frame sample parser, predicts the result
// items of every accepted byte and compares them in order with the output.
// ----------------------------------------------------------------------------
module afsp_result_checker
	import afsp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] rx_byte
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [31:0] m_tdata,   // [9:0] sample_index, [29:10] result_value, [31:30] 0
	input  logic [3:0]  m_tuser,   // [2:0] result_kind, [3] frame_done
	input  logic        m_tlast,   // run_last
	output int unsigned fail_count,
	output int unsigned outstanding
);

	typedef struct packed {
		kind_t            kind;
		logic [IDX_W-1:0] idx;
		logic [VAL_W-1:0] val;
		logic             done;
		logic             last;
	} result_t;

	result_t expected_results[$];
	result_t exp_r;
	int unsigned errs;

	// parser state
	logic                  meta_on;
	logic [NUM_FIELDS-1:0] fld_on;
	logic [NUM_FIELDS-1:0] fld_stop;
	logic [FCNT_W-1:0]     fld_cnt [NUM_FIELDS];
	logic [VAL_W-1:0]      fld_acc [NUM_FIELDS];
	logic                  data_on;
	logic [HCNT_W-1:0]     hex_cnt;
	logic [SMP_W-1:0]      hex_acc;
	logic                  hex_stop;
	logic [IDX_W-1:0]      smp_cnt;

	function automatic result_t make_result(input kind_t k, input logic [IDX_W-1:0] i,
			input logic [VAL_W-1:0] v, input logic d);
		result_t r;
		r.kind = k;
		r.idx  = i;
		r.val  = v;
		r.done = d;
		r.last = 1'b0;
		return r;
	endfunction

	task automatic parse_byte(input logic [7:0] b);
		int f;
		int p;
		int n;
		logic [3:0] nib;
		logic nib_ok;
		logic [IDX_W-1:0] idx;
		n = 0;
		// abort: data mode off, index back to zero, metadata kept
		if (b == CH_DOT) begin
			data_on = 1'b0;
			smp_cnt = '0;
			return;
		end
		if (b == CH_S || meta_on) begin
			meta_on = 1'b1;
			for (f = 0; f < NUM_FIELDS; f++) begin
				if (b == FIELD_LETTER[f]) begin
					fld_on[f]   = 1'b1;
					fld_cnt[f]  = '0;
					fld_acc[f]  = '0;
					fld_stop[f] = 1'b0;
				end else if (fld_on[f]) begin
					if (!fld_stop[f] && b >= CH_0 && b <= CH_9) begin
						fld_acc[f] = VAL_W'(fld_acc[f] * 10 + (b - CH_0));
					end else begin
						fld_stop[f] = 1'b1;
					end
					fld_cnt[f]++;
					if (fld_cnt[f] >= FIELD_DIGITS) begin
						fld_on[f]  = 1'b0;
						fld_cnt[f] = '0;
						expected_results.push_back(make_result(kind_t'(f + 1), '0,
							fld_acc[f], 1'b0));
						n++;
						// c closes the header; this same byte goes on as data
						if (f == NUM_FIELDS - 1) begin
							meta_on  = 1'b0;
							data_on  = 1'b1;
							smp_cnt  = '0;
							hex_cnt  = '0;
							hex_acc  = '0;
							hex_stop = 1'b0;
						end
					end
				end
			end
		end
		if (data_on) begin
			if (b == CH_COMMA) begin
				hex_cnt  = '0;
				hex_acc  = '0;
				hex_stop = 1'b0;
			end else if (hex_cnt < HEX_DIGITS) begin
				nib_ok = 1'b1;
				if (b >= CH_0 && b <= CH_9) begin
					nib = 4'(b - CH_0);
				end else if (b >= CH_LA && b <= CH_LF) begin
					nib = 4'(b - CH_LA + 8'd10);
				end else if (b >= CH_UA && b <= CH_UF) begin
					nib = 4'(b - CH_UA + 8'd10);
				end else begin
					nib    = '0;
					nib_ok = 1'b0;
				end
				if (!hex_stop && nib_ok) begin
					hex_acc = {hex_acc[SMP_W-5:0], nib};
				end else begin
					hex_stop = 1'b1;
				end
				hex_cnt++;
				if (hex_cnt == HEX_DIGITS) begin
					idx     = smp_cnt;
					smp_cnt = smp_cnt + 1'b1;
					if (idx + 1 >= REAL_SAMPLES) begin
						// last real sample, then copies up to the end of the frame
						data_on = 1'b0;
						if (PAD_ROOM) begin
							expected_results.push_back(make_result(KIND_SAMPLE, idx,
								VAL_W'(hex_acc), 1'b0));
							n++;
							for (p = REAL_SAMPLES; p < FRAME_SAMPLES; p++) begin
								expected_results.push_back(make_result(KIND_SAMPLE,
									IDX_W'(p), VAL_W'(hex_acc), p + 1 == FRAME_SAMPLES));
								n++;
							end
						end else begin
							expected_results.push_back(make_result(KIND_SAMPLE, idx,
								VAL_W'(hex_acc), 1'b1));
							n++;
						end
					end else begin
						expected_results.push_back(make_result(KIND_SAMPLE, idx,
							VAL_W'(hex_acc), 1'b0));
						n++;
					end
				end
			end
		end
		if (n > 0) begin
			expected_results[expected_results.size() - 1].last = 1'b1;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			meta_on  = 1'b0;
			fld_on   = '0;
			fld_stop = '0;
			for (int f = 0; f < NUM_FIELDS; f++) begin
				fld_cnt[f] = '0;
				fld_acc[f] = '0;
			end
			data_on  = 1'b0;
			hex_cnt  = '0;
			hex_acc  = '0;
			hex_stop = 1'b0;
			smp_cnt  = '0;
			expected_results.delete();
			errs = 0;
			fail_count  <= 0;
			outstanding <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (expected_results.size() == 0) begin
					errs++;
					$error("result item with none expected: tdata %h tuser %h tlast %b",
						m_tdata, m_tuser, m_tlast);
				end else begin
					exp_r = expected_results.pop_front();
					if (m_tuser[2:0] !== exp_r.kind) begin
						errs++;
						$error("result_kind: expected %0d, actual %0d", exp_r.kind,
							m_tuser[2:0]);
					end
					if (m_tdata[9:0] !== exp_r.idx) begin
						errs++;
						$error("sample_index: expected %0d, actual %0d", exp_r.idx,
							m_tdata[9:0]);
					end
					if (m_tdata[29:10] !== exp_r.val) begin
						errs++;
						$error("result_value: expected %0d, actual %0d", exp_r.val,
							m_tdata[29:10]);
					end
					if (m_tuser[3] !== exp_r.done) begin
						errs++;
						$error("frame_done: expected %0d, actual %0d", exp_r.done,
							m_tuser[3]);
					end
					if (m_tlast !== exp_r.last) begin
						errs++;
						$error("run_last: expected %0d, actual %0d", exp_r.last, m_tlast);
					end
				end
			end
			// a byte's results pass through the job and output registers before they come out
			if (s_tvalid && s_tready) begin
				parse_byte(s_tdata);
			end
			fail_count  <= errs;
			outstanding <= expected_results.size();
		end
	end

endmodule

// ===== bench/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Byte stream stimulus for the ASCII frame sample parser: a short directed
// frame, random headers and sample runs with noise and aborts, under
// changing idle patterns on both sides.
// ----------------------------------------------------------------------------
module tb;
	import afsp_pkg::*;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic [7:0]  s_tdata  = '0;
	logic        m_tready = 1'b0;
	wire         s_tready;
	wire         m_tvalid;
	wire  [31:0] m_tdata;
	wire  [3:0]  m_tuser;
	wire         m_tlast;

	int unsigned fail_count;
	int unsigned outstanding;
	int unsigned snd_idle_pct  = 0;
	int unsigned rcv_idle_pct  = 0;
	int unsigned hold_requests = 0;
	int unsigned holds_seen    = 0;
	int unsigned hold_left     = 0;
	int unsigned items_sent    = 0;

	// S, p 999999, c 12345 with its last char as first hex digit, "aBz" -> 0x0AB,
	// an ignored extra char, a sample with non-hex bytes 0x00 and 0xFF, abort
	localparam logic [7:0] DIRECTED [24] = '{
		CH_S, CH_P, "9", "9", "9", "9", "9", "9",
		CH_C, "1", "2", "3", "4", "5", "a", "B", "z",
		"9", CH_COMMA,
		8'h00, 8'hff, "0", CH_COMMA,
		CH_DOT
	};

	ascii_frame_sample_parser dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	afsp_result_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tuser     (m_tuser),
		.m_tlast     (m_tlast),
		.fail_count  (fail_count),
		.outstanding (outstanding)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// receiver: random back-pressure, or a long hold when asked
	always @(posedge clk) begin
		if (hold_requests != holds_seen) begin
			holds_seen <= hold_requests;
			hold_left  <= 400;
			m_tready   <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			m_tready  <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= rcv_idle_pct);
		end
	end

	task automatic send_byte(input logic [7:0] b);
		while ($urandom_range(99) < snd_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		items_sent++;
	endtask

	// clean chars never hit S, comma or dot
	function automatic logic [7:0] sample_char(input bit clean);
		int unsigned r;
		r = $urandom_range(19);
		if (r == 0) begin
			return clean ? 8'(8'h67 + $urandom_range(6)) : 8'($urandom_range(255));
		end
		if (r < 6) begin
			return CH_UA + 8'($urandom_range(5));
		end
		if (r < 11) begin
			return CH_LA + 8'($urandom_range(5));
		end
		return CH_0 + 8'($urandom_range(9));
	endfunction

	function automatic logic [7:0] field_char(input bit clean);
		if ($urandom_range(19) < 17) begin
			return CH_0 + 8'($urandom_range(9));
		end
		return clean ? 8'(8'h67 + $urandom_range(6)) : 8'($urandom_range(255));
	endfunction

	task automatic send_field(input logic [7:0] letter, input bit clean);
		bit nines;
		nines = ($urandom_range(15) == 0);
		send_byte(letter);
		repeat (FIELD_DIGITS) send_byte(nines ? CH_9 : field_char(clean));
	endtask

	task automatic send_header(input bit clean);
		logic [7:0] lead [3] = '{CH_P, CH_N, CH_D};
		int unsigned k;
		k = $urandom_range(2);
		send_byte(CH_S);
		for (int i = 0; i < 3; i++) begin
			if ($urandom_range(3) != 0) begin
				send_field(lead[2'((k + i) % 3)], clean);
			end
		end
		send_field(CH_C, clean);
	endtask

	task automatic send_samples(input int unsigned n, input bit clean);
		repeat (n) begin
			repeat (HEX_DIGITS) send_byte(sample_char(clean));
			if ($urandom_range(6) == 0) begin
				repeat ($urandom_range(1, 2)) send_byte(sample_char(clean));
			end
			send_byte(CH_COMMA);
		end
	endtask

	task automatic random_traffic(input int unsigned n_items);
		int unsigned stop_at;
		stop_at = items_sent + n_items;
		while (items_sent < stop_at) begin
			case ($urandom_range(9))
				0, 1, 2, 3: begin
					send_header(1'($urandom_range(1)));
					send_samples($urandom_range(1, 12), 1'($urandom_range(1)));
				end
				4, 5: send_samples($urandom_range(1, 6), 1'b0);
				6: send_byte(CH_DOT);
				7: begin
					// metadata reopened, possibly while data mode runs
					send_byte(CH_S);
					send_field(FIELD_LETTER[2'($urandom_range(NUM_FIELDS - 1))], 1'b0);
				end
				8: repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(255)));
				default: send_field(FIELD_LETTER[2'($urandom_range(NUM_FIELDS - 1))], 1'b0);
			endcase
		end
	endtask

	// sender pause until every expected item has come out
	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		snd_idle_pct = 17;
		rcv_idle_pct <= 63;
		foreach (DIRECTED[i]) send_byte(DIRECTED[i]);
		drain();
		random_traffic(70);
		drain();

		snd_idle_pct = 63;
		rcv_idle_pct <= 17;
		random_traffic(70);
		drain();

		snd_idle_pct = 0;
		rcv_idle_pct <= 0;
		send_header(1'b1);
		hold_requests <= hold_requests + 1;
		send_samples(12, 1'b1);
		random_traffic(20);
		drain();
		repeat (10) @(posedge clk);

		if (fail_count == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

	initial begin
		#5_000_000;
		$display("simulation failed");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/afsp_pkg.sv
rtl/ascii_frame_sample_parser.sv
bench/afsp_result_checker.sv
bench/tb.sv
